@@ hw/rtl/alpha_bleed_dilate_3x3_macros.svh @@
// ---------------------------------------------------------------------------
// alpha_bleed_dilate_3x3 assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ALPHA_BLEED_DILATE_3X3_MACROS_SVH
`define ALPHA_BLEED_DILATE_3X3_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define ABD3_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("abd3 assertion failed");
// Next-cycle implication.
`define ABD3_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abd3 assertion failed");
`else
`define ABD3_ASSERT_IMP(label, clk, rst, ante, cons)
`define ABD3_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/abd3_pkg.sv @@
// ---------------------------------------------------------------------------
// abd3_pkg
// Types, widths and the reciprocal helper function shared by the alpha bleed blocks.
// ---------------------------------------------------------------------------
package abd3_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int WIDTH_RESET_DEF = 2048;
  localparam int MAX_HEIGHT      = 4096;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 4 * CH_W;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int OROW_W     = 12;
  localparam int IROW_W     = 13;
  localparam int SUM_W      = 11;
  localparam int CNT_W      = 4;
  localparam int RECIP_W    = 15;
  localparam int RECIP_SHIFT = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_DIV
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch pixel, read line stores
    logic shift;     // shift window, write line stores, advance input position
    logic sum;       // register neighbor sums and count
    logic load_out;  // load output register, advance output position
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ignore;    // flush item while pixels are still expected
    logic emit;      // current item produces a result
    logic out_free;  // output register can take a result this cycle
  } sts_t;

  // ceil(2^RECIP_SHIFT / n); exact quotient for sums below 2^SUM_W.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 15'd16384;
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5462;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3277;
      4'd6:    r = 15'd2731;
      4'd7:    r = 15'd2341;
      4'd8:    r = 15'd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/abd3_ctrl.sv @@
// ---------------------------------------------------------------------------
// abd3_ctrl
// Sequencer for one item: capture, shift, sum, divide and hand off.
// ---------------------------------------------------------------------------
module abd3_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  abd3_pkg::sts_t sts,
  output abd3_pkg::cmd_t cmd
);
  import abd3_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        // drop ignored flush items without touching state
        if (s_tvalid && !sts.ignore) begin
          cmd.capture = 1'b1;
          state_next  = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (sts.emit) begin
          cmd.sum    = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/abd3_datapath.sv @@
// ---------------------------------------------------------------------------
// abd3_datapath
// Line stores, 3x3 window, neighbor sums, reciprocal divide, output register.
// ---------------------------------------------------------------------------
`include "alpha_bleed_dilate_3x3_macros.svh"

module abd3_datapath #(
  parameter int MAX_WIDTH = abd3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [abd3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [abd3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [abd3_pkg::PIX_W-1:0]        s_tdata,
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [abd3_pkg::PIX_W-1:0]        m_tdata,
  output logic                              m_tlast,
  input  abd3_pkg::cmd_t                    cmd,
  output abd3_pkg::sts_t                    sts
);
  import abd3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int WIDTH_RESET = (MAX_WIDTH < WIDTH_RESET_DEF) ? MAX_WIDTH : WIDTH_RESET_DEF;

  // Configuration
  logic [WIDTH_W-1:0]  width;
  logic [HEIGHT_W-1:0] height;
  logic [WIDTH_W-1:0]  width_next;
  logic [HEIGHT_W-1:0] height_next;

  // Positions
  logic [COL_W-1:0]  in_col;
  logic [IROW_W-1:0] in_row;
  logic [COL_W-1:0]  out_col;
  logic [OROW_W-1:0] out_row;

  // Line stores: upper half is the older row, lower half the newer one
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0]   pix_q;
  logic [PIX_W-1:0]   win [3][3];
  logic               emit_q;

  // Sum stage
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PIX_W-1:0] centre_q;
  logic             centre_nz_q;
  logic             last, last_q;
  logic             row_first, row_last, col_first, col_last;

  // Divide stage
  logic [RECIP_W-1:0]       rcp;
  logic [SUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;
  logic [PIX_W-1:0]         result;

  logic in_col_wrap;
  logic out_col_wrap;
  logic padding;

  assign padding    = in_row >= height;
  assign sts.ignore = !padding && s_tuser;
  assign sts.emit   = emit_q;
  assign sts.out_free = !m_tvalid || m_tready;

  // Clamp configuration writes into range
  always_comb begin
    width_next  = cfg_data[WIDTH_W-1:0];
    height_next = cfg_data[HEIGHT_W-1:0];
    if (width_next == '0) begin
      width_next = WIDTH_W'(1);
    end else if (int'(width_next) > MAX_WIDTH) begin
      width_next = WIDTH_W'(MAX_WIDTH);
    end
    if (height_next == '0) begin
      height_next = HEIGHT_W'(1);
    end else if (int'(height_next) > MAX_HEIGHT) begin
      height_next = HEIGHT_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WIDTH_W'(WIDTH_RESET);
      height <= HEIGHT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width  <= width_next;
        REG_HEIGHT: height <= height_next;
        default: ;
      endcase
    end
  end

  assign in_col_wrap  = (CMP_W'(in_col) + CMP_W'(1)) >= CMP_W'(width);
  assign out_col_wrap = (CMP_W'(out_col) + CMP_W'(1)) >= CMP_W'(width);

  // Position counters; a config write or the last result restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_we || (cmd.load_out && last_q)) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (cmd.shift) begin
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row + IROW_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (cmd.load_out) begin
        if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row + OROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // Line store port: read on capture, write back on shift at the same column
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_q  <= line_mem[in_col];
      pix_q <= padding ? '0 : s_tdata;
    end
    if (cmd.shift) begin
      line_mem[in_col] <= {rd_q[PIX_W-1:0], pix_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
      emit_q <= 1'b0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd_q[2*PIX_W-1:PIX_W];
      win[1][2] <= rd_q[PIX_W-1:0];
      win[2][2] <= pix_q;
      emit_q    <= (in_row >= IROW_W'(2)) || ((in_row == IROW_W'(1)) && (in_col != '0));
    end
  end

  // Neighbor selection and sums
  assign row_first = out_row == '0;
  assign row_last  = (IROW_W'(out_row) + IROW_W'(1)) >= height;
  assign col_first = out_col == '0;
  assign col_last  = out_col_wrap;
  assign last      = row_last && col_last;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    cnt   = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && !(r == 0 && row_first) && !(r == 2 && row_last) &&
            !(c == 0 && col_first) && !(c == 2 && col_last) && (win[r][c] != '0)) begin
          cnt   = cnt + CNT_W'(1);
          sum_r = sum_r + SUM_W'(win[r][c][CH_W-1:0]);
          sum_g = sum_g + SUM_W'(win[r][c][2*CH_W-1:CH_W]);
          sum_b = sum_b + SUM_W'(win[r][c][3*CH_W-1:2*CH_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r_q     <= sum_r;
      sum_g_q     <= sum_g;
      sum_b_q     <= sum_b;
      cnt_q       <= cnt;
      centre_q    <= win[1][1];
      centre_nz_q <= win[1][1] != '0;
      last_q      <= last;
    end
  end

  // Divide by the count through a reciprocal multiply
  assign rcp    = recip(cnt_q);
  assign prod_r = (SUM_W+RECIP_W)'(sum_r_q) * (SUM_W+RECIP_W)'(rcp);
  assign prod_g = (SUM_W+RECIP_W)'(sum_g_q) * (SUM_W+RECIP_W)'(rcp);
  assign prod_b = (SUM_W+RECIP_W)'(sum_b_q) * (SUM_W+RECIP_W)'(rcp);
  assign result = centre_nz_q ? centre_q :
                  {{CH_W{1'b0}}, prod_b[RECIP_SHIFT +: CH_W],
                   prod_g[RECIP_SHIFT +: CH_W], prod_r[RECIP_SHIFT +: CH_W]};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= result;
      m_tlast <= last_q;
    end
  end

  `ABD3_ASSERT_IMP(a_no_clobber, clk, rst, cmd.load_out, (!m_tvalid || m_tready))
  `ABD3_ASSERT_NXT(a_last_restarts, clk, rst, (cmd.load_out && last_q),
                   (in_col == '0 && in_row == '0 && out_col == '0 && out_row == '0))
  `ABD3_ASSERT_NXT(a_empty_stays_zero, clk, rst, (cmd.load_out && !centre_nz_q && cnt_q == '0),
                   (m_tdata == '0))

endmodule

@@ hw/rtl/alpha_bleed_dilate_3x3.sv @@
// ---------------------------------------------------------------------------
// alpha_bleed_dilate_3x3
// One alpha bleed pass over a raster RGBA stream with a 3x3 neighborhood.
// ---------------------------------------------------------------------------
// Usage:
//   Set image_width (index 0) and image_height (index 1) through cfg_we /
//   cfg_index / cfg_data while the block is idle; any write restarts the frame.
//   Send W*H pixels on the s_ channel, then W+1 flush items (s_tuser = 1).
//   A flush item that arrives while pixels are still expected is taken and
//   dropped. Results leave on the m_ channel, one per pixel, in raster order,
//   lagging their pixel by one row plus one item; m_tlast marks the last pixel
//   of the frame, after which the next item starts a new frame.
// Sequence:
//   An item with a result goes through capture with line store read, window
//   shift with write-back, neighbor sum and reciprocal divide into the output
//   register; one without a result ends after the sum step, and a dropped flush
//   item is only taken. A new item waits until the last one is done.
//   A result reaches m_tvalid when its item leaves the divide step.
// Reset and stalls:
//   rst (synchronous) clears the window, counters and output valid; width
//   resets to 2048 (or MAX_WIDTH if smaller) and height to 1. Line stores are
//   not cleared. A stalled receiver holds the result; the next item is still
//   taken and worked up to the divide step, where it waits for the register.
// ---------------------------------------------------------------------------
module alpha_bleed_dilate_3x3 #(
  parameter int MAX_WIDTH = abd3_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [abd3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abd3_pkg::CFG_DATA_W-1:0] cfg_data,
  // Pixel input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [abd3_pkg::PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic                            s_tuser,   // flush
  // Pixel output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [abd3_pkg::PIX_W-1:0]      m_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic                            m_tlast    // last_of_frame
);
  import abd3_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: one item at a time through the four steps
  abd3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Line stores, window, arithmetic and output register
  abd3_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
